// ----- rtl/windowed_nearest_path_point_defines.svh -----
// Assertion macros shared by the controller and datapath RTL files.
`ifndef WINDOWED_NEAREST_PATH_POINT_DEFINES_SVH
`define WINDOWED_NEAREST_PATH_POINT_DEFINES_SVH

// Checks that a condition implies another on the same clock edge.
`define WNP_ASSERT_IMP(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// Checks that a condition implies another on the next clock edge.
`define WNP_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ----- rtl/wnpp_pkg.sv -----
// ----------------------------------------------------------------------------
// wnpp_pkg
// Types, constants and codes shared by the path point matcher.
// ----------------------------------------------------------------------------
package wnpp_pkg;

  localparam int MaxPoints  = 4096;
  localparam int MaxWindow  = 64;
  localparam int MaxPreview = 32;
  localparam int IdxW       = $clog2(MaxPoints);
  localparam int CntW       = IdxW + 1;

  localparam logic [1:0] FUNC_APPEND  = 2'd0;
  localparam logic [1:0] FUNC_MATCH_M = 2'd1;
  localparam logic [1:0] FUNC_MATCH_S = 2'd2;
  localparam logic [1:0] FUNC_PREVIEW = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_NO_PREV = 2'd3;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [5:0]         prev_len;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [11:0]        point_index;
    logic [25:0]        distance;
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic               last;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SHORT, S_APPEND, S_MSCAN, S_MWAIT, S_SQRT, S_MOUT,
    S_PREAD, S_POUT
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic latch;      // capture input item
    logic setup;      // load scan range after decode
    logic write_pt;   // store appended point
    logic rd_next;    // issue read at scan address, advance it
    logic cmp;        // compare read point against best
    logic sqrt_start;
    logic sqrt_step;
    logic set_trk;    // move tracker to best
    logic emit;       // present result
    logic emit_kind;  // 0 match/append/short, 1 preview
  } ctl_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic [1:0] func;
    logic       full;
    logic       empty_win;
    logic       no_prev;
    logic       rd_done;   // all reads issued
    logic       sqrt_done;
  } sts_t;

endpackage

// ----- rtl/wnpp_ctrl.sv -----
// ----------------------------------------------------------------------------
// wnpp_ctrl
// Controller state machine sequencing append, match and preview work.
// ----------------------------------------------------------------------------
`include "windowed_nearest_path_point_defines.svh"
module wnpp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  wnpp_pkg::sts_t sts,
  output logic           busy,
  output wnpp_pkg::ctl_t ctl
);
  import wnpp_pkg::*;

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (start) state_nxt = S_SHORT;
      S_SHORT: begin
        unique case (sts.func)
          FUNC_APPEND: state_nxt = S_APPEND;
          FUNC_MATCH_M, FUNC_MATCH_S: state_nxt = sts.empty_win ? S_MOUT : S_MSCAN;
          default: state_nxt = sts.no_prev ? S_MOUT : S_PREAD;
        endcase
      end
      S_APPEND: state_nxt = S_IDLE;
      S_MSCAN:  if (sts.rd_done) state_nxt = S_MWAIT;
      S_MWAIT:  state_nxt = S_SQRT;
      S_SQRT:   if (sts.sqrt_done) state_nxt = S_MOUT;
      S_MOUT:   state_nxt = S_IDLE;
      S_PREAD:  state_nxt = S_POUT;
      S_POUT:   if (sts.rd_done) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    ctl = '0;
    busy = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE:   ctl.latch = start;
      S_SHORT:  ctl.setup = 1'b1;
      S_APPEND: begin
        ctl.write_pt = 1'b1;
        ctl.emit = 1'b1;
      end
      S_MSCAN: begin
        ctl.cmp = 1'b1;
        ctl.rd_next = !sts.rd_done;
      end
      S_MWAIT:  ctl.sqrt_start = 1'b1;
      S_SQRT:   ctl.sqrt_step = 1'b1;
      S_MOUT: begin
        ctl.emit = 1'b1;
        ctl.set_trk = !sts.empty_win && !sts.no_prev;
      end
      S_PREAD:  ctl.rd_next = 1'b1;
      S_POUT: begin
        ctl.emit = 1'b1;
        ctl.emit_kind = 1'b1;
        ctl.rd_next = !sts.rd_done;
      end
      default: ;
    endcase
  end

  `WNP_ASSERT_IMP(a_emit_busy, clk, rst_n, ctl.emit, busy)
  `WNP_ASSERT_NEXT(a_latch_busy, clk, rst_n, ctl.latch, busy)
  `WNP_ASSERT_IMP(a_one_cmd, clk, rst_n, busy, !(ctl.write_pt && ctl.cmp))
endmodule

// ----- rtl/wnpp_path.sv -----
// ----------------------------------------------------------------------------
// wnpp_path
// Datapath: point memory, trackers, distance compare and integer root.
// ----------------------------------------------------------------------------
`include "windowed_nearest_path_point_defines.svh"
module wnpp_path (
  input  logic                clk,
  input  logic                rst_n,
  input  wnpp_pkg::in_item_t  in_item,
  input  logic                cfg_we,
  input  logic [6:0]          cfg_wdata,
  input  wnpp_pkg::ctl_t      ctl,
  output wnpp_pkg::sts_t      sts,
  output logic                out_valid,
  output wnpp_pkg::out_item_t out_item
);
  import wnpp_pkg::*;

  logic [47:0]        mem [MaxPoints];
  logic [47:0]        rdata_r;
  in_item_t           item_r;
  logic [6:0]         win_r;
  logic [CntW-1:0]    count_r;
  logic [IdxW-1:0]    main_r, second_r;
  logic [CntW-1:0]    addr_r, end_r;      // next read address and bound
  logic [IdxW-1:0]    cmp_idx_r;           // index of rdata
  logic [IdxW-1:0]    best_r;
  logic [47:0]        best_pt_r;
  logic [48:0]        bestd_r;
  logic               first_r;
  logic [49:0]        rad_r;               // radicand pairs still to consume
  logic [25:0]        rem_r;
  logic [25:0]        root_r;
  logic [4:0]         sq_cnt_r;
  logic               rd_vld_r;
  logic               out_valid_r;
  out_item_t          out_r;
  out_item_t          out_nxt;

  logic [IdxW-1:0]    trk;
  logic [6:0]         w_sat;
  logic [5:0]         n_sat;
  logic [CntW-1:0]    w_end, p_end, avail;
  logic signed [24:0] dx, dy;
  logic [24:0]        ax, ay;
  logic [48:0]        dsq;
  logic [27:0]        rem_sh;
  logic [27:0]        tst;

  assign trk   = (item_r.func == FUNC_MATCH_S) ? second_r : main_r;
  assign w_sat = (win_r > 7'(MaxWindow)) ? 7'(MaxWindow) : win_r;
  assign n_sat = (item_r.prev_len > 6'(MaxPreview)) ? 6'(MaxPreview)
                                                     : item_r.prev_len;
  assign w_end = (({1'b0, trk} + CntW'(w_sat)) > count_r) ? count_r
                                                            : ({1'b0, trk} + CntW'(w_sat));
  assign avail = (({1'b0, main_r} + 1'b1) < count_r) ? (count_r - {1'b0, main_r} - 1'b1)
                                                      : '0;
  assign p_end = {1'b0, main_r} + 1'b1 + ((CntW'(n_sat) > avail) ? avail : CntW'(n_sat));

  // Squared distance of the point just read.
  assign dx  = 25'(signed'(rdata_r[47:24])) - 25'(item_r.pos_x);
  assign dy  = 25'(signed'(rdata_r[23:0]))  - 25'(item_r.pos_y);
  assign ax  = dx[24] ? 25'(-dx) : 25'(dx);
  assign ay  = dy[24] ? 25'(-dy) : 25'(dy);
  assign dsq = 49'(ax * ax) + 49'(ay * ay);

  // One root digit per cycle: bring down two radicand bits, try 4q+1.
  assign rem_sh = {rem_r, rad_r[49:48]};
  assign tst    = {root_r, 2'b01};

  assign sts.func      = item_r.func;
  assign sts.full      = count_r >= CntW'(MaxPoints);
  assign sts.empty_win = (item_r.func != FUNC_APPEND) && (item_r.func != FUNC_PREVIEW) &&
                         ((w_sat == '0) || ({1'b0, trk} >= count_r));
  assign sts.no_prev   = (item_r.func == FUNC_PREVIEW) && (p_end == {1'b0, main_r} + 1'b1);
  assign sts.rd_done   = (addr_r >= end_r);
  assign sts.sqrt_done = (sq_cnt_r == 5'd0);

  // Memory port: write on append, read at scan address.
  always_ff @(posedge clk) begin
    if (ctl.write_pt && !sts.full)
      mem[count_r[IdxW-1:0]] <= {item_r.pos_x, item_r.pos_y};
    rdata_r <= mem[addr_r[IdxW-1:0]];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= 7'd16;
      count_r <= '0;
      main_r <= '0;
      second_r <= '0;
      out_valid_r <= 1'b0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cfg_we) win_r <= cfg_wdata;
      if (ctl.write_pt && !sts.full) count_r <= count_r + 1'b1;
      if (ctl.set_trk && item_r.func == FUNC_MATCH_M) main_r <= best_r;
      if (ctl.set_trk && item_r.func == FUNC_MATCH_S) second_r <= best_r;
      out_valid_r <= ctl.emit;
      rd_vld_r <= ctl.rd_next;
    end
  end

  // Result of the current transaction, chosen by kind.
  always_comb begin
    out_nxt = '0;
    out_nxt.last = 1'b1;
    priority if (item_r.func == FUNC_APPEND) begin
      if (sts.full) out_nxt.status = ST_FULL;
      else begin
        out_nxt.point_index = count_r[IdxW-1:0];
        out_nxt.point_x = item_r.pos_x;
        out_nxt.point_y = item_r.pos_y;
      end
    end else if (ctl.emit_kind) begin
      out_nxt.point_index = cmp_idx_r;
      out_nxt.point_x = rdata_r[47:24];
      out_nxt.point_y = rdata_r[23:0];
      out_nxt.last = sts.rd_done;
    end else if (sts.empty_win) begin
      out_nxt.status = ST_EMPTY;
      out_nxt.point_index = trk;
    end else if (sts.no_prev) begin
      out_nxt.status = ST_NO_PREV;
      out_nxt.point_index = main_r;
    end else begin
      out_nxt.point_index = best_r;
      out_nxt.distance = root_r;
      out_nxt.point_x = best_pt_r[47:24];
      out_nxt.point_y = best_pt_r[23:0];
    end
  end

  // Scan, compare, root and result registers.
  always_ff @(posedge clk) begin
    if (ctl.latch) item_r <= in_item;
    if (ctl.setup) begin
      // Load the scan range once the item is decoded.
      if (item_r.func == FUNC_PREVIEW) begin
        addr_r <= {1'b0, main_r} + 1'b1;
        end_r <= p_end;
      end else begin
        addr_r <= {1'b0, trk};
        end_r <= w_end;
      end
    end else if (ctl.rd_next) begin
      addr_r <= addr_r + 1'b1;
      cmp_idx_r <= addr_r[IdxW-1:0];
    end
    if (ctl.setup) begin
      first_r <= 1'b1;
    end else if (ctl.cmp && rd_vld_r) begin
      first_r <= 1'b0;
      if (first_r || dsq < bestd_r) begin
        bestd_r <= dsq;
        best_r <= cmp_idx_r;
        best_pt_r <= rdata_r;
      end
    end
    if (ctl.sqrt_start) begin
      rad_r <= {1'b0, bestd_r};
      rem_r <= '0;
      root_r <= '0;
      sq_cnt_r <= 5'd25;
    end else if (ctl.sqrt_step && !sts.sqrt_done) begin
      sq_cnt_r <= sq_cnt_r - 1'b1;
      rad_r <= {rad_r[47:0], 2'b00};
      if (rem_sh >= tst) begin
        rem_r <= 26'(rem_sh - tst);
        root_r <= {root_r[24:0], 1'b1};
      end else begin
        rem_r <= rem_sh[25:0];
        root_r <= {root_r[24:0], 1'b0};
      end
    end
    if (ctl.emit) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `WNP_ASSERT_IMP(a_count_max, clk, rst_n, 1'b1, count_r <= CntW'(MaxPoints))
  `WNP_ASSERT_IMP(a_trk_in, clk, rst_n, ctl.set_trk, {1'b0, best_r} < count_r)
  `WNP_ASSERT_NEXT(a_emit_v, clk, rst_n, ctl.emit, out_valid_r)
endmodule

// ----- rtl/windowed_nearest_path_point.sv -----
// ----------------------------------------------------------------------------
// windowed_nearest_path_point
// Path point table with windowed nearest-point match and preview.
// ----------------------------------------------------------------------------
// One transaction at a time: start is taken at a clock edge where busy is low.
// An append, a match on an empty window or a preview with nothing to return
// keeps busy high through decode and one result state, and shows its result in
// the first cycle that busy is low again. A match over n points keeps busy high
// through decode, the scan at one memory read a cycle through the single
// memory port, the root setup, the root steps and the result register; the
// window holds at most 64 points. A preview of n points keeps busy high through
// decode, its first read and its output state, and returns one point a cycle.
// Results appear for one cycle on out_valid and cannot be stalled; the next
// transaction may be taken in the cycle that the final result shows. Unwritten
// table entries are never read, so no clearing pass runs after reset.
module windowed_nearest_path_point (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  wnpp_pkg::in_item_t  in_item,
  input  logic                cfg_we,
  input  logic [6:0]          cfg_wdata,
  output logic                out_valid,
  output wnpp_pkg::out_item_t out_item
);
  import wnpp_pkg::*;

  ctl_t ctl;
  sts_t sts;

  wnpp_ctrl u_ctrl (.clk, .rst_n, .start, .sts, .busy, .ctl);
  wnpp_path u_path (.clk, .rst_n, .in_item, .cfg_we, .cfg_wdata, .ctl, .sts,
                    .out_valid, .out_item);
endmodule

// ----- tb/tb_windowed_nearest_path_point.sv -----
// ----------------------------------------------------------------------------
// tb_windowed_nearest_path_point
// Self-checking bench for the path point matcher: directed corner cases,
// then random append, match and preview traffic under several search windows,
// all scored against a local predictor or, for some directed rows, hand-written answers.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_windowed_nearest_path_point;
  import wnpp_pkg::*;

  localparam int WatchLimit = 2000;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      cfg_we;
  logic [6:0] cfg_wdata;
  logic      out_valid;
  out_item_t out_item;

  windowed_nearest_path_point DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  // Predictor state: the path table, the trackers and the window setting.
  logic signed [23:0] path_x [MaxPoints];
  logic signed [23:0] path_y [MaxPoints];
  int        point_cnt;
  int        main_trk;
  int        second_trk;
  int        window_reg;

  out_item_t expected_q[$];
  bit        in_taken;
  bit        typed_valid;
  out_item_t typed_exp;
  bit        no_idle;
  int        mismatches;
  int        items_in;
  int        results_out;
  int        idle_cycles;

  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t ex;
  } row_t;
  row_t directed_rows[$];

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'h1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned dist_sq(int idx, int x, int y);
    longint dx;
    longint dy;
    dx = longint'(path_x[idx]) - longint'(x);
    dy = longint'(path_y[idx]) - longint'(y);
    return longint'(dx * dx) + longint'(dy * dy);
  endfunction

  function automatic out_item_t mk_res(logic [1:0] st, int idx, int dist_val,
                                       int x, int y, bit lst);
    out_item_t r;
    r.status      = st;
    r.point_index = idx[11:0];
    r.distance    = dist_val[25:0];
    r.point_x     = x[23:0];
    r.point_y     = y[23:0];
    r.last        = lst;
    return r;
  endfunction

  function automatic in_item_t mk_item(logic [1:0] f, int x, int y, int plen);
    in_item_t it;
    it.func     = f;
    it.pos_x    = x[23:0];
    it.pos_y    = y[23:0];
    it.prev_len = plen[5:0];
    return it;
  endfunction

  // Appends one expected result to the scoreboard queue.
  task automatic queue_result(input out_item_t r);
    expected_q.insert(expected_q.size(), r);
  endtask

  // Adds one row to the directed stimulus table.
  task automatic add_row(input in_item_t it, input bit typed, input out_item_t ex);
    row_t r;
    r.it    = it;
    r.typed = typed;
    r.ex    = ex;
    directed_rows.insert(directed_rows.size(), r);
  endtask

  // Works out the results of one accepted transaction and updates the state.
  task automatic predict_results(input in_item_t it);
    int trk;
    int w;
    int last_i;
    int best;
    int n;
    int avail;
    longint unsigned d;
    longint unsigned bd;
    case (it.func)
      FUNC_APPEND: begin
        if (point_cnt >= MaxPoints) begin
          queue_result(mk_res(ST_FULL, 0, 0, 0, 0, 1'b1));
        end else begin
          path_x[point_cnt] = it.pos_x;
          path_y[point_cnt] = it.pos_y;
          queue_result(mk_res(ST_OK, point_cnt, 0, int'(it.pos_x), int'(it.pos_y),
                              1'b1));
          point_cnt++;
        end
      end
      FUNC_MATCH_M, FUNC_MATCH_S: begin
        trk = (it.func == FUNC_MATCH_M) ? main_trk : second_trk;
        w   = (window_reg > MaxWindow) ? MaxWindow : window_reg;
        if (w == 0 || trk >= point_cnt) begin
          queue_result(mk_res(ST_EMPTY, trk, 0, 0, 0, 1'b1));
        end else begin
          last_i = (trk + w > point_cnt) ? point_cnt : trk + w;
          best   = trk;
          bd     = dist_sq(trk, int'(it.pos_x), int'(it.pos_y));
          for (int i = trk + 1; i < last_i; i++) begin
            d = dist_sq(i, int'(it.pos_x), int'(it.pos_y));
            if (d < bd) begin
              bd   = d;
              best = i;
            end
          end
          if (it.func == FUNC_MATCH_M) main_trk = best;
          else second_trk = best;
          queue_result(mk_res(ST_OK, best, int'(root_floor(bd)),
                              int'(path_x[best]), int'(path_y[best]), 1'b1));
        end
      end
      default: begin
        n     = (int'(it.prev_len) > MaxPreview) ? MaxPreview : int'(it.prev_len);
        avail = (main_trk + 1 < point_cnt) ? point_cnt - 1 - main_trk : 0;
        if (n > avail) n = avail;
        if (n == 0) begin
          queue_result(mk_res(ST_NO_PREV, main_trk, 0, 0, 0, 1'b1));
        end else begin
          for (int k = 0; k < n; k++) begin
            queue_result(mk_res(ST_OK, main_trk + 1 + k, 0,
                                int'(path_x[main_trk + 1 + k]),
                                int'(path_y[main_trk + 1 + k]), k + 1 == n));
          end
        end
      end
    endcase
  endtask

  // Input acceptance, prediction and result scoring on the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      in_taken = start && !busy;
      if (in_taken) begin
        items_in++;
        predict_results(in_item);
        // Directed rows with a hand-written answer replace the predicted one.
        if (typed_valid) expected_q[$] = typed_exp;
      end
      if (out_valid) begin
        results_out++;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result, index %0d", out_item.point_index);
        end else if (out_item !== expected_q[0]) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp st=%0d idx=%0d dist=%0d x=%0d y=%0d last=%0d",
                     expected_q[0].status, expected_q[0].point_index,
                     expected_q[0].distance, expected_q[0].point_x,
                     expected_q[0].point_y, expected_q[0].last);
            $display("          got st=%0d idx=%0d dist=%0d x=%0d y=%0d last=%0d",
                     out_item.status, out_item.point_index, out_item.distance,
                     out_item.point_x, out_item.point_y, out_item.last);
          end
          void'(expected_q.pop_front());
        end else begin
          void'(expected_q.pop_front());
        end
      end
      // Watchdog on cycles without any transaction.
      if (in_taken || out_valid) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchLimit) begin
        $display("timeout with %0d results outstanding", expected_q.size());
        $display("tb_windowed_nearest_path_point failed");
        $finish;
      end
    end
  end

  // Presents one transaction at the falling edge and holds it until taken.
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t ex);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_item     = it;
    typed_valid = typed;
    typed_exp   = ex;
    start       = 1'b1;
    do @(negedge clk); while (!in_taken);
    start       = 1'b0;
    typed_valid = 1'b0;
  endtask

  // Waits until every expected result has come and the block is idle.
  task automatic drain_results();
    start = 1'b0;
    while (expected_q.size() != 0 || busy) @(negedge clk);
    repeat (5) @(negedge clk);
  endtask

  task automatic write_window(input int v);
    drain_results();
    cfg_we    = 1'b1;
    cfg_wdata = v[6:0];
    @(negedge clk);
    cfg_we     = 1'b0;
    window_reg = v;
  endtask

  // Random transaction, mostly following a winding path so matches land near it.
  int walk_x;
  int walk_y;
  function automatic in_item_t random_item();
    int sel;
    int idx;
    int x;
    int y;
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      if ($urandom_range(0, 7) == 0) begin
        x = $urandom;
        y = $urandom;
      end else begin
        walk_x += int'($urandom_range(0, 8192)) - 4096;
        walk_y += int'($urandom_range(0, 8192)) - 4096;
        x = walk_x;
        y = walk_y;
      end
      return mk_item(FUNC_APPEND, x, y, $urandom_range(0, 63));
    end else if (sel < 75) begin
      if (point_cnt == 0 || $urandom_range(0, 9) == 0) begin
        x = $urandom;
        y = $urandom;
      end else begin
        idx = $urandom_range(0, point_cnt - 1);
        x = int'(path_x[idx]) + int'($urandom_range(0, 6000)) - 3000;
        y = int'(path_y[idx]) + int'($urandom_range(0, 6000)) - 3000;
      end
      return mk_item((sel < 55) ? FUNC_MATCH_M : FUNC_MATCH_S, x, y,
                     $urandom_range(0, 63));
    end
    return mk_item(FUNC_PREVIEW, $urandom, $urandom,
                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                               : $urandom_range(0, 12));
  endfunction

  initial begin
    int        windows[6];
    out_item_t none;
    none        = '0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_item     = '0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    typed_valid = 1'b0;
    typed_exp   = '0;
    no_idle     = 1'b0;
    window_reg  = 16;
    walk_x      = 0;
    walk_y      = 0;

    // Directed rows: empty table, coordinate extremes, saturation, ties.
    add_row(mk_item(FUNC_MATCH_M, 100, 100, 0), 1'b1,
            mk_res(ST_EMPTY, 0, 0, 0, 0, 1'b1));
    add_row(mk_item(FUNC_MATCH_S, -5, 7, 0), 1'b1,
            mk_res(ST_EMPTY, 0, 0, 0, 0, 1'b1));
    add_row(mk_item(FUNC_PREVIEW, 0, 0, 5), 1'b1,
            mk_res(ST_NO_PREV, 0, 0, 0, 0, 1'b1));
    add_row(mk_item(FUNC_APPEND, -8388608, 8388607, 63), 1'b1,
            mk_res(ST_OK, 0, 0, -8388608, 8388607, 1'b1));
    add_row(mk_item(FUNC_APPEND, 8388607, -8388608, 0), 1'b1,
            mk_res(ST_OK, 1, 0, 8388607, -8388608, 1'b1));
    add_row(mk_item(FUNC_APPEND, 0, 0, 0), 1'b1,
            mk_res(ST_OK, 2, 0, 0, 0, 1'b1));
    add_row(mk_item(FUNC_APPEND, 1024, -1024, 0), 1'b1,
            mk_res(ST_OK, 3, 0, 1024, -1024, 1'b1));
    add_row(mk_item(FUNC_APPEND, -1, -1, 0), 1'b1,
            mk_res(ST_OK, 4, 0, -1, -1, 1'b1));
    add_row(mk_item(FUNC_MATCH_M, 0, 0, 0), 1'b1,
            mk_res(ST_OK, 2, 0, 0, 0, 1'b1));
    add_row(mk_item(FUNC_PREVIEW, 0, 0, 0), 1'b1,
            mk_res(ST_NO_PREV, 2, 0, 0, 0, 1'b1));
    add_row(mk_item(FUNC_PREVIEW, 0, 0, 63), 1'b0, none);
    add_row(mk_item(FUNC_MATCH_S, 8388607, -8388608, 0), 1'b1,
            mk_res(ST_OK, 1, 0, 8388607, -8388608, 1'b1));
    add_row(mk_item(FUNC_MATCH_M, -8388608, 8388607, 0), 1'b0, none);
    add_row(mk_item(FUNC_APPEND, 0, 0, 0), 1'b0, none);
    add_row(mk_item(FUNC_APPEND, 1024, 0, 0), 1'b0, none);
    add_row(mk_item(FUNC_APPEND, -1024, 0, 0), 1'b0, none);
    // Equal distances: the lowest index must win.
    add_row(mk_item(FUNC_MATCH_S, 10, 10, 0), 1'b0, none);
    add_row(mk_item(FUNC_MATCH_M, 0, 4000, 0), 1'b0, none);
    add_row(mk_item(FUNC_PREVIEW, -8388608, 8388607, 32), 1'b0, none);
    add_row(mk_item(FUNC_PREVIEW, 8388607, -8388608, 1), 1'b0, none);
    add_row(mk_item(FUNC_MATCH_M, 8388607, 8388607, 0), 1'b0, none);
    add_row(mk_item(FUNC_MATCH_S, -8388608, -8388608, 0), 1'b0, none);

    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) send_item(directed_rows[i].it, directed_rows[i].typed,
                                         directed_rows[i].ex);

    // Random phases, each under its own window; the sender fully drains first.
    windows = '{1, 0, 64, 127, 16, 0};
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 4) windows[ph] = $urandom_range(2, 63);
      if (ph == 5) begin
        windows[ph] = $urandom_range(1, 127);
        no_idle = 1'b1;
      end
      write_window(windows[ph]);
      repeat (50) send_item(random_item(), 1'b0, none);
    end

    // Closing traffic under the full window, back to back.
    write_window(64);
    repeat (20) send_item(random_item(), 1'b0, none);
    send_item(mk_item(FUNC_PREVIEW, 0, 0, 63), 1'b0, none);

    drain_results();
    repeat (40) @(negedge clk);
    if (expected_q.size() != 0) begin
      mismatches++;
      $display("%0d expected results never arrived", expected_q.size());
    end

    $display("Covered %0d transactions and %0d results: empty table, extremes, ties,",
             items_in, results_out);
    $display("and six window settings including zero and saturation; %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("tb_windowed_nearest_path_point passed");
    end else begin
      $display("tb_windowed_nearest_path_point failed");
    end
    $finish;
  end

endmodule
